// ===== rtl/core/shh_pkg.sv =====
// ----------------------------------------------------------------------------
// shh_pkg
// Shared constants and types for the hmax heuristic engine.
// ----------------------------------------------------------------------------
`default_nettype none

package shh_pkg;

    localparam int MAX_FACTS = 64;
    localparam int MAX_OPS   = 256;

    localparam int FIDX_W = $clog2(MAX_FACTS);
    localparam int FCNT_W = $clog2(MAX_FACTS + 1);
    localparam int OIDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int OCNT_W = $clog2(MAX_OPS + 1);

    localparam int MASK_W = 64;
    localparam int COST_W = 32;
    localparam int PRICE_W = 31;
    localparam int PEND_W = 7;
    localparam int OPW_W  = PRICE_W + 2 * MASK_W;

    localparam logic [COST_W-1:0] COST_SAT = '1;

    localparam logic [1:0] CFG_FACT_COUNT = 2'd0;
    localparam logic [1:0] CFG_OP_COUNT   = 2'd1;
    localparam logic [1:0] CFG_GOAL_MASK  = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INITF,
        S_OPRD,
        S_OPCHK,
        S_OFFER,
        S_ITER,
        S_MIN,
        S_FIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/strips_hmax_heuristic.sv =====
// ----------------------------------------------------------------------------
// strips_hmax_heuristic
// hmax delete-relaxation heuristic engine with operator table in RAM.
// ----------------------------------------------------------------------------
// A load word writes one operator entry. An evaluate word runs a Dijkstra-style
// walk built from RAM scans: it seeds all MAX_FACTS fact costs, then scans the
// operators once to count preconditions, then per settled fact runs the goal
// check and minimum scan and the operator scan, plus a fact scan for every
// operator whose add effects are offered, and ends with a final goal scan.
// Configuration is taken at any time and is always ready; write it only while
// no evaluation runs.
`default_nettype none

module strips_hmax_heuristic (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_kind,
    input  wire logic [7:0]                  i_op_slot,
    input  wire logic [shh_pkg::MASK_W-1:0]  i_pre_facts,
    input  wire logic [shh_pkg::MASK_W-1:0]  i_add_facts,
    input  wire logic [shh_pkg::PRICE_W-1:0] i_op_price,
    input  wire logic [shh_pkg::MASK_W-1:0]  i_state_facts,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [shh_pkg::COST_W-1:0]       o_heuristic,
    output logic                             o_unreachable,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [63:0]                 i_cfg_data
);

    import shh_pkg::*;

    t_state r_state, n_state;

    logic [6:0]        r_fact_count;
    logic [8:0]        r_op_count;
    logic [MASK_W-1:0] r_goal;

    logic [FCNT_W-1:0] r_f, n_f;
    logic              r_rv, n_rv;
    logic [FIDX_W-1:0] r_ri, n_ri;
    logic              r_relax, n_relax;
    logic [OCNT_W-1:0] r_o, n_o;
    logic [FCNT_W-1:0] r_iter, n_iter;
    logic [FIDX_W-1:0] r_k, n_k;
    logic              r_kv, n_kv;
    logic [COST_W-1:0] r_best, n_best;
    logic [COST_W-1:0] r_base, n_base;
    logic [COST_W-1:0] r_c, n_c;
    logic [MASK_W-1:0] r_add, n_add;
    logic [MASK_W-1:0] r_settled, n_settled;
    logic [MASK_W-1:0] r_smask, n_smask;
    logic [COST_W-1:0] r_h, n_h;
    logic              r_ov, n_ov;
    logic [COST_W-1:0] r_hout, n_hout;

    logic [FCNT_W-1:0] nf;
    logic [OCNT_W-1:0] no;
    logic [MASK_W-1:0] used;
    logic [MASK_W-1:0] goal_u;

    // RAM ports
    logic              op_we;
    logic [OIDX_W-1:0] op_raddr;
    logic [OPW_W-1:0]  op_wdata, op_rdata;
    logic              pend_we;
    logic [PEND_W-1:0] pend_wdata, pend_rdata;
    logic              cost_we;
    logic [FIDX_W-1:0] cost_waddr;
    logic [COST_W-1:0] cost_wdata, cost_rdata;

    logic [MASK_W-1:0]  pre_u, add_u;
    logic [PRICE_W-1:0] price_q;
    logic               hit;
    logic [PEND_W-1:0]  pend_dec;
    logic               fire;
    logic [COST_W:0]    sum;
    logic [COST_W-1:0]  relax_c;
    logic [OCNT_W-1:0]  o_inc;
    logic               o_more;
    logic               scan_done;
    logic               in_acc, out_acc;

    assign nf = (r_fact_count > 7'(MAX_FACTS)) ? FCNT_W'(MAX_FACTS) : FCNT_W'(r_fact_count);
    assign no = ({4'd0, r_op_count} > 13'(MAX_OPS)) ? OCNT_W'(MAX_OPS) : OCNT_W'(r_op_count);
    assign used = (nf >= FCNT_W'(MASK_W)) ? '1 : ((MASK_W'(1) << nf) - MASK_W'(1));
    assign goal_u = r_goal & used;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_ov && !i_out_stall;

    assign o_out_valid   = r_ov;
    assign o_heuristic   = r_hout;
    assign o_unreachable = (r_hout == COST_SAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fact_count <= 7'(MAX_FACTS);
            r_op_count   <= '0;
            r_goal       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FACT_COUNT: r_fact_count <= i_cfg_data[6:0];
                CFG_OP_COUNT:   r_op_count   <= i_cfg_data[8:0];
                CFG_GOAL_MASK:  r_goal       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operator table
    assign op_we    = in_acc && (i_kind == KIND_LOAD) && ({1'b0, i_op_slot} < 9'(MAX_OPS));
    assign op_wdata = {i_op_price, i_add_facts, i_pre_facts};
    assign o_inc    = r_o + OCNT_W'(1);
    assign o_more   = (o_inc < no);
    assign op_raddr = (r_state == S_OPCHK) ? o_inc[OIDX_W-1:0] : r_o[OIDX_W-1:0];

    shh_ram #(.WIDTH(OPW_W), .DEPTH(MAX_OPS)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (i_op_slot[OIDX_W-1:0]),
        .i_wdata (op_wdata),
        .i_raddr (op_raddr),
        .o_rdata (op_rdata)
    );

    shh_ram #(.WIDTH(PEND_W), .DEPTH(MAX_OPS)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (r_o[OIDX_W-1:0]),
        .i_wdata (pend_wdata),
        .i_raddr (op_raddr),
        .o_rdata (pend_rdata)
    );

    shh_ram #(.WIDTH(COST_W), .DEPTH(MAX_FACTS)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (cost_waddr),
        .i_wdata (cost_wdata),
        .i_raddr (r_f[FIDX_W-1:0]),
        .o_rdata (cost_rdata)
    );

    assign pre_u    = op_rdata[MASK_W-1:0] & used;
    assign add_u    = op_rdata[2*MASK_W-1:MASK_W] & used;
    assign price_q  = op_rdata[OPW_W-1:2*MASK_W];
    assign hit      = pre_u[r_k];
    assign pend_dec = (pend_rdata == '0) ? '0 : pend_rdata - PEND_W'(1);
    assign sum      = {1'b0, r_base} + {2'b0, price_q};
    assign relax_c  = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
    assign fire     = (add_u != '0) &&
                      (r_relax ? (hit && pend_dec == '0) : (pre_u == '0));
    assign scan_done = (r_f >= nf) && !r_rv;

    always_comb begin
        n_state   = r_state;
        n_f       = r_f;
        n_rv      = r_rv;
        n_ri      = r_ri;
        n_relax   = r_relax;
        n_o       = r_o;
        n_iter    = r_iter;
        n_k       = r_k;
        n_kv      = r_kv;
        n_best    = r_best;
        n_base    = r_base;
        n_c       = r_c;
        n_add     = r_add;
        n_settled = r_settled;
        n_smask   = r_smask;
        n_h       = r_h;
        n_ov      = out_acc ? 1'b0 : r_ov;
        n_hout    = r_hout;

        pend_we    = 1'b0;
        pend_wdata = r_relax ? pend_dec : PEND_W'($countones(pre_u));
        cost_we    = 1'b0;
        cost_waddr = r_ri;
        cost_wdata = r_c;

        // scan pipeline: issue read at r_f, data for r_ri arrives from the registered RAM read
        if (r_state == S_MIN || r_state == S_FIN || r_state == S_OFFER) begin
            if (r_f < nf) begin
                n_rv = 1'b1;
                n_ri = r_f[FIDX_W-1:0];
                n_f  = r_f + FCNT_W'(1);
            end else begin
                n_rv = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == KIND_EVAL) begin
                    n_smask   = i_state_facts & used;
                    n_settled = '0;
                    n_iter    = '0;
                    n_f       = '0;
                    n_state   = S_INITF;
                end
            end
            S_INITF: begin
                cost_we    = 1'b1;
                cost_waddr = r_f[FIDX_W-1:0];
                cost_wdata = r_smask[r_f[FIDX_W-1:0]] ? '0 : COST_SAT;
                n_f        = r_f + FCNT_W'(1);
                if (r_f == FCNT_W'(MAX_FACTS - 1)) begin
                    n_relax = 1'b0;
                    n_o     = '0;
                    n_state = (no == '0) ? S_ITER : S_OPRD;
                end
            end
            S_OPRD: begin
                n_state = S_OPCHK;
            end
            S_OPCHK: begin
                pend_we = r_relax ? hit : 1'b1;
                if (fire) begin
                    n_add   = add_u;
                    n_c     = r_relax ? relax_c : {1'b0, price_q};
                    n_f     = '0;
                    n_rv    = 1'b0;
                    n_state = S_OFFER;
                end else if (o_more) begin
                    n_o = o_inc;
                end else begin
                    if (r_relax) begin
                        n_iter = r_iter + FCNT_W'(1);
                    end
                    n_state = S_ITER;
                end
            end
            S_OFFER: begin
                if (r_rv && r_add[r_ri] && cost_rdata > r_c) begin
                    cost_we = 1'b1;
                end
                if (scan_done) begin
                    if (o_more) begin
                        n_o     = o_inc;
                        n_state = S_OPRD;
                    end else begin
                        if (r_relax) begin
                            n_iter = r_iter + FCNT_W'(1);
                        end
                        n_state = S_ITER;
                    end
                end
            end
            S_ITER: begin
                n_f  = '0;
                n_rv = 1'b0;
                if (r_iter < nf && (goal_u & ~r_settled) != '0) begin
                    n_kv    = 1'b0;
                    n_state = S_MIN;
                end else begin
                    n_h     = '0;
                    n_state = S_FIN;
                end
            end
            S_MIN: begin
                if (r_rv && !r_settled[r_ri] && (!r_kv || cost_rdata < r_best)) begin
                    n_k    = r_ri;
                    n_kv   = 1'b1;
                    n_best = cost_rdata;
                end
                if (scan_done) begin
                    if (!r_kv) begin
                        n_h     = '0;
                        n_f     = '0;
                        n_rv    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_settled[r_k] = 1'b1;
                        n_base  = r_best;
                        n_relax = 1'b1;
                        n_o     = '0;
                        if (no == '0) begin
                            n_iter  = r_iter + FCNT_W'(1);
                            n_state = S_ITER;
                        end else begin
                            n_state = S_OPRD;
                        end
                    end
                end
            end
            S_FIN: begin
                if (r_rv && goal_u[r_ri] && cost_rdata > r_h) begin
                    n_h = cost_rdata;
                end
                if (scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_ov || out_acc) begin
                    n_ov    = 1'b1;
                    n_hout  = r_h;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_f       <= '0;
            r_rv      <= 1'b0;
            r_relax   <= 1'b0;
            r_o       <= '0;
            r_iter    <= '0;
            r_kv      <= 1'b0;
            r_settled <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_f       <= n_f;
            r_rv      <= n_rv;
            r_relax   <= n_relax;
            r_o       <= n_o;
            r_iter    <= n_iter;
            r_kv      <= n_kv;
            r_settled <= n_settled;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri    <= n_ri;
        r_k     <= n_k;
        r_best  <= n_best;
        r_base  <= n_base;
        r_c     <= n_c;
        r_add   <= n_add;
        r_smask <= n_smask;
        r_h     <= n_h;
        r_hout  <= n_hout;
    end

`ifndef SYNTHESIS
    a_settle_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN && scan_done && r_kv) |=> r_settled[r_k])
        else $error("settled fact not marked");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPCHK && r_relax && hit) |-> (pend_rdata != '0))
        else $error("pending precondition count underflow");

    a_offer_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFFER && cost_we) |-> (r_c < cost_rdata))
        else $error("offer raised a fact cost");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == KIND_EVAL) |=> (r_state == S_INITF && o_in_stall))
        else $error("evaluation did not start");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/shh_ram.sv =====
// ----------------------------------------------------------------------------
// shh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
